[sv/pfr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page framebuffer refresher package
// Field widths, item modes and panel command bytes shared by the project.
// ----------------------------------------------------------------------------
package pfr_pkg;

    localparam int MODE_W   = 3;
    localparam int COLUMN_W = 7;
    localparam int ROW_W    = 6;
    localparam int PAGE_W   = 3;
    localparam int BYTE_W   = 8;

    typedef enum logic [MODE_W-1:0] {
        MODE_PIXEL   = 3'd0,
        MODE_BYTE    = 3'd1,
        MODE_CLEAR   = 3'd2,
        MODE_REFRESH = 3'd3,
        MODE_TICK    = 3'd4
    } mode_t;

    localparam logic [BYTE_W-1:0] CMD_PAGE_BASE = 8'hB0;
    localparam logic [BYTE_W-1:0] CMD_COL_LOW   = 8'h00;
    localparam logic [BYTE_W-1:0] CMD_COL_HIGH  = 8'h10;
    localparam int                HEADER_STEPS  = 3;

endpackage

[sv/pfr_req_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page framebuffer refresher request channel
// Valid/ready channel that carries one request item per transaction.
// ----------------------------------------------------------------------------
interface pfr_req_if
    import pfr_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [MODE_W-1:0]   mode;
    logic [COLUMN_W-1:0] column;
    logic [ROW_W-1:0]    row;
    logic [PAGE_W-1:0]   page;
    logic                pixel_on;
    logic [BYTE_W-1:0]   data_byte;

    modport source (
        output valid, mode, column, row, page, pixel_on, data_byte,
        input  ready
    );

    modport sink (
        input  valid, mode, column, row, page, pixel_on, data_byte,
        output ready
    );
endinterface

[sv/pfr_byte_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page framebuffer refresher panel byte channel
// Valid/ready channel that carries one panel byte per transaction.
// ----------------------------------------------------------------------------
interface pfr_byte_if
    import pfr_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              is_data;
    logic              frame_end;

    modport source (
        output valid, out_byte, is_data, frame_end,
        input  ready
    );

    modport sink (
        input  valid, out_byte, is_data, frame_end,
        output ready
    );
endinterface

[sv/page_framebuffer_refresher.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page framebuffer refresher
// Byte-per-column framebuffer for a page-organized monochrome panel, with a
// tick-driven refresh sequencer that streams command and data bytes.
// ----------------------------------------------------------------------------
// The block takes one request transaction per clock cycle while it is not
// held off: pixel sets, byte writes, refresh starts and ticks all flow at
// that rate, because every item makes exactly one access to the single frame
// memory and read-modify-write conflicts between neighboring items are
// resolved by a bypass on the read port. A tick during a refresh passes
// from the second stage into the output register to produce its panel byte;
// a waiting panel byte only holds off a request while a later tick result is
// stuck behind it. A clear, and also reset, zeroes the memory with a sweep of
// one entry per cycle over all 2**(clog2(COLUMNS)+max(clog2(PAGES),1)) entries
// (1024 at the default 128 x 8), during which no request is accepted.
// ----------------------------------------------------------------------------
module page_framebuffer_refresher
    import pfr_pkg::*;
#(
    parameter int COLUMNS = 128,
    parameter int PAGES   = 8
) (
    input  logic       clk,
    input  logic       rst_n,
    pfr_req_if.sink    request,
    pfr_byte_if.source panel
);

    // Memory geometry: the address is {column, page}.
    localparam int CW    = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam int PW    = (PAGES > 1) ? $clog2(PAGES) : 1;
    localparam int AW    = CW + PW;
    localparam int DEPTH = 1 << AW;
    localparam int SW    = $clog2(COLUMNS + HEADER_STEPS);

    localparam logic [SW-1:0] LAST_STEP  = SW'(COLUMNS + HEADER_STEPS - 1);
    localparam logic [SW-1:0] FIRST_DATA = SW'(HEADER_STEPS);
    localparam logic [PW-1:0] LAST_PAGE  = PW'(PAGES - 1);
    localparam logic [8:0]    COL_LIMIT  = 9'(COLUMNS);
    localparam logic [4:0]    PAGE_LIMIT = 5'(PAGES);

    // ------------------------------------------------------------------
    // Frame memory and its read port.
    // ------------------------------------------------------------------
    logic [BYTE_W-1:0] frame_mem [DEPTH];
    logic [BYTE_W-1:0] rd_data_reg;
    logic [AW-1:0]     rd_addr;
    logic              mem_we;
    logic [AW-1:0]     wr_addr;
    logic [BYTE_W-1:0] wr_data;

    // Clear sweep.
    logic          clear_busy_reg, clear_busy_next;
    logic [AW-1:0] sweep_addr_reg, sweep_addr_next;

    // Refresh sequencer.
    logic          refresh_active_reg, refresh_active_next;
    logic [PW-1:0] refresh_page_reg, refresh_page_next;
    logic [SW-1:0] refresh_step_reg, refresh_step_next;

    // Second stage: the item whose memory read has just returned.
    logic              s1_valid_reg;
    logic              s1_write_reg;
    logic              s1_pixel_reg;
    logic              s1_on_reg;
    logic [BYTE_W-1:0] s1_mask_reg;
    logic [BYTE_W-1:0] s1_byte_reg;
    logic [AW-1:0]     s1_addr_reg;
    logic              s1_result_reg;
    logic              s1_data_reg;
    logic              s1_last_reg;
    logic [BYTE_W-1:0] s1_cmd_reg;
    logic              s1_stall;

    // Output register.
    logic              out_valid_reg;
    logic [BYTE_W-1:0] out_byte_reg;
    logic              out_data_reg;
    logic              out_last_reg;
    logic              out_load;

    // Request decode.
    logic              in_fire;
    logic              is_tick;
    logic              is_start;
    logic [8:0]        col_ext;
    logic [4:0]        row_page_ext;
    logic [4:0]        page_ext;
    logic              col_ok;
    logic              write_ok;
    logic [PW-1:0]     write_page;
    logic [CW-1:0]     tick_col;
    logic [BYTE_W-1:0] pixel_mask;
    logic [BYTE_W-1:0] s1_new_byte;
    logic [BYTE_W-1:0] tick_cmd;

    // A tick result that cannot move into a full output register holds the
    // second stage, and with it the request side.
    assign s1_stall      = s1_valid_reg && s1_result_reg && out_valid_reg && !panel.ready;
    assign request.ready = !clear_busy_reg && !s1_stall;
    assign in_fire       = request.valid && request.ready;

    assign is_tick  = (request.mode == MODE_TICK);
    assign is_start = (request.mode == MODE_CLEAR) || (request.mode == MODE_REFRESH);

    assign col_ext      = 9'(request.column);
    assign row_page_ext = 5'(request.row[ROW_W-1:3]);
    assign page_ext     = 5'(request.page);
    assign col_ok       = col_ext < COL_LIMIT;
    assign pixel_mask   = BYTE_W'(1) << request.row[2:0];

    always_comb
    begin
        write_ok   = 1'b0;
        write_page = row_page_ext[PW-1:0];
        case (request.mode)
            MODE_PIXEL:
            begin
                write_ok   = col_ok && (row_page_ext < PAGE_LIMIT);
                write_page = row_page_ext[PW-1:0];
            end
            MODE_BYTE:
            begin
                write_ok   = col_ok && (page_ext < PAGE_LIMIT);
                write_page = page_ext[PW-1:0];
            end
            default:
            begin
                write_ok   = 1'b0;
                write_page = row_page_ext[PW-1:0];
            end
        endcase
    end

    assign tick_col = CW'(refresh_step_reg - FIRST_DATA);
    assign rd_addr  = is_tick ? {tick_col, refresh_page_reg}
                              : {col_ext[CW-1:0], write_page};

    always_comb
    begin
        case (refresh_step_reg)
            SW'(0):  tick_cmd = CMD_PAGE_BASE + BYTE_W'(refresh_page_reg);
            SW'(1):  tick_cmd = CMD_COL_LOW;
            default: tick_cmd = CMD_COL_HIGH;
        endcase
    end

    // Read-modify-write of a pixel happens in the second stage.
    assign s1_new_byte = !s1_pixel_reg ? s1_byte_reg
                       : (s1_on_reg ? (rd_data_reg | s1_mask_reg)
                                    : (rd_data_reg & ~s1_mask_reg));

    // The sweep owns the write port while it runs; no item write is in flight then.
    assign mem_we  = clear_busy_reg || (s1_valid_reg && s1_write_reg);
    assign wr_addr = clear_busy_reg ? sweep_addr_reg : s1_addr_reg;
    assign wr_data = clear_busy_reg ? '0 : s1_new_byte;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            frame_mem[wr_addr] <= wr_data;
        end
        if (in_fire)
        begin
            // Bypass the write that lands on the same edge, so that a
            // back-to-back access to one entry sees the newest byte.
            if (mem_we && (wr_addr == rd_addr))
            begin
                rd_data_reg <= wr_data;
            end
            else
            begin
                rd_data_reg <= frame_mem[rd_addr];
            end
        end
    end

    // ------------------------------------------------------------------
    // Refresh sequencer: advances at the edge that accepts the tick.
    // ------------------------------------------------------------------
    always_comb
    begin
        refresh_active_next = refresh_active_reg;
        refresh_page_next   = refresh_page_reg;
        refresh_step_next   = refresh_step_reg;
        if (in_fire && is_start)
        begin
            refresh_active_next = 1'b1;
            refresh_page_next   = '0;
            refresh_step_next   = '0;
        end
        else if (in_fire && is_tick && refresh_active_reg)
        begin
            if (refresh_step_reg == LAST_STEP)
            begin
                refresh_step_next = '0;
                if (refresh_page_reg == LAST_PAGE)
                begin
                    refresh_page_next   = '0;
                    refresh_active_next = 1'b0;
                end
                else
                begin
                    refresh_page_next = refresh_page_reg + PW'(1);
                end
            end
            else
            begin
                refresh_step_next = refresh_step_reg + SW'(1);
            end
        end
    end

    // Clear sweep: runs after reset and after every accepted clear.
    always_comb
    begin
        clear_busy_next = clear_busy_reg;
        sweep_addr_next = sweep_addr_reg;
        if (clear_busy_reg)
        begin
            sweep_addr_next = sweep_addr_reg + AW'(1);
            if (sweep_addr_reg == {AW{1'b1}})
            begin
                clear_busy_next = 1'b0;
            end
        end
        else if (in_fire && (request.mode == MODE_CLEAR))
        begin
            clear_busy_next = 1'b1;
            sweep_addr_next = '0;
        end
    end

    assign out_load = s1_valid_reg && s1_result_reg && (!out_valid_reg || panel.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_busy_reg     <= 1'b1;
            sweep_addr_reg     <= '0;
            refresh_active_reg <= 1'b0;
            refresh_page_reg   <= '0;
            refresh_step_reg   <= '0;
            s1_valid_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            clear_busy_reg     <= clear_busy_next;
            sweep_addr_reg     <= sweep_addr_next;
            refresh_active_reg <= refresh_active_next;
            refresh_page_reg   <= refresh_page_next;
            refresh_step_reg   <= refresh_step_next;
            if (!s1_stall)
            begin
                s1_valid_reg <= in_fire;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (panel.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_write_reg  <= write_ok;
            s1_pixel_reg  <= (request.mode == MODE_PIXEL);
            s1_on_reg     <= request.pixel_on;
            s1_mask_reg   <= pixel_mask;
            s1_byte_reg   <= request.data_byte;
            s1_addr_reg   <= rd_addr;
            s1_result_reg <= is_tick && refresh_active_reg;
            s1_data_reg   <= refresh_step_reg >= FIRST_DATA;
            s1_last_reg   <= (refresh_step_reg == LAST_STEP) && (refresh_page_reg == LAST_PAGE);
            s1_cmd_reg    <= tick_cmd;
        end
        if (out_load)
        begin
            out_byte_reg <= s1_data_reg ? rd_data_reg : s1_cmd_reg;
            out_data_reg <= s1_data_reg;
            out_last_reg <= s1_last_reg;
        end
    end

    assign panel.valid     = out_valid_reg;
    assign panel.out_byte  = out_byte_reg;
    assign panel.is_data   = out_data_reg;
    assign panel.frame_end = out_last_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // No item write may compete with the clear sweep for the write port.
    a_sweep_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        clear_busy_reg |-> !(s1_valid_reg && s1_write_reg))
        else $error("item write during clear sweep");

    // A start restarts the refresh at page 0, step 0.
    a_start_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && is_start) |=>
            (refresh_active_reg && (refresh_page_reg == '0) && (refresh_step_reg == '0)))
        else $error("refresh start did not restart the sequencer");

    // The byte that ends the frame leaves the sequencer idle.
    a_frame_end_stops: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_result_reg && s1_last_reg) |-> !refresh_active_reg)
        else $error("refresh still active after last frame byte");

    // The sweep only ends after it has visited the last entry.
    a_sweep_complete: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(clear_busy_reg) |-> ($past(sweep_addr_reg) == {AW{1'b1}}))
        else $error("clear sweep ended early");

    // A result is only formed in data phase or with a command byte, and a
    // frame end is always a data byte.
    a_frame_end_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!s1_last_reg || s1_data_reg))
        else $error("frame end flagged on a command byte");

endmodule
